/* rtl/ptts_pkg.sv */
// Package for the periodic task tick scheduler: slot count, item structs,
// command codes and the microcode ROM. Used by every file in rtl/.
package ptts_pkg;

   localparam int TASK_SLOTS = 8;
   localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int STEP_W     = 3;

   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_CREATE  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_SUSPEND = 3'd3,
      OP_RESUME  = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [2:0]  task_index;
      logic [15:0] period;
      logic [15:0] first_delay;
   } req_type;

   typedef struct packed {
      logic [2:0] run_task;
      logic       last_of_tick;
   } rsp_type;

   // Datapath action of one microcode step, one-hot.
   typedef enum logic [4:0] {
      ACT_IDLE     = 5'b00001,
      ACT_DISPATCH = 5'b00010,
      ACT_APPLY    = 5'b00100,
      ACT_SCAN     = 5'b01000,
      ACT_FLUSH    = 5'b10000
   } action_type;

   // Jump condition: jump to target when true, else advance by one.
   typedef enum logic [1:0] {
      COND_ALWAYS  = 2'd0,
      COND_NOSTART = 2'd1,
      COND_TICK    = 2'd2,
      COND_MORE    = 2'd3
   } cond_type;

   typedef struct packed {
      action_type            action;
      cond_type              cond;
      logic [STEP_W-1:0]     target;
   } uword_type;

   // Step addresses of the program.
   localparam logic [STEP_W-1:0] STEP_IDLE     = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
   localparam logic [STEP_W-1:0] STEP_APPLY    = 3'd2;
   localparam logic [STEP_W-1:0] STEP_SCAN     = 3'd3;
   localparam logic [STEP_W-1:0] STEP_FLUSH    = 3'd4;

   function automatic uword_type ucode_rom(input logic [STEP_W-1:0] step);
      uword_type w;
      case (step)
         STEP_IDLE:     w = '{ACT_IDLE,     COND_NOSTART, STEP_IDLE};
         STEP_DISPATCH: w = '{ACT_DISPATCH, COND_TICK,    STEP_SCAN};
         STEP_APPLY:    w = '{ACT_APPLY,    COND_ALWAYS,  STEP_IDLE};
         STEP_SCAN:     w = '{ACT_SCAN,     COND_MORE,    STEP_SCAN};
         STEP_FLUSH:    w = '{ACT_FLUSH,    COND_ALWAYS,  STEP_IDLE};
         default:       w = '{ACT_IDLE,     COND_ALWAYS,  STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/ptts_seq.sv */
// Microcode sequencer of the task scheduler: step counter, control ROM
// and jump logic. Depends on ptts_pkg.
module ptts_seq
   import ptts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic      is_tick,
   input  logic      more_slots,
   output uword_type uword
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              take_jump;

   assign uword = ucode_rom(step_ff);

   always_comb begin
      case (uword.cond)
         COND_ALWAYS:  take_jump = 1'b1;
         COND_NOSTART: take_jump = !start;
         COND_TICK:    take_jump = is_tick;
         COND_MORE:    take_jump = more_slots;
         default:      take_jump = 1'b1;
      endcase
      step_in = take_jump ? uword.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

/* rtl/periodic_task_tick_scheduler_core.sv */
// Periodic task tick scheduler: slot table datapath driven by ptts_seq.
// Steps: a command passes idle/accept, dispatch and apply; a tick passes accept,
// dispatch, one slot per cycle over all TASK_SLOTS slots, and flush. busy is high outside idle.
// A run event is held until the next due slot is scanned; the last one of a tick
// leaves after the flush step, in the cycle where the next item can be taken.
// Synchronous active-high reset clears present and resumed marks; no receiver stall.
module periodic_task_tick_scheduler_core
   import ptts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_strobe,
   output rsp_type rsp_item
);

   uword_type uword;

   req_type               item_ff;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [TASK_SLOTS-1:0] present_ff, present_in;
   logic [TASK_SLOTS-1:0] resumed_ff, resumed_in;
   logic [15:0]           period_ff    [TASK_SLOTS];
   logic [15:0]           countdown_ff [TASK_SLOTS];
   logic                  pend_ff, pend_in;
   logic [SLOT_W-1:0]     pend_slot_ff, pend_slot_in;
   logic                  strobe_ff, strobe_in;
   rsp_type               rsp_ff, rsp_in;

   logic              accept;
   logic              is_tick;
   logic              more_slots;
   logic              idx_ok;
   logic [SLOT_W-1:0] cmd_slot;
   logic              live;
   logic              due;
   logic [15:0]       cnt_now;

   assign busy     = (uword.action != ACT_IDLE);
   assign accept   = start && !busy;
   assign is_tick  = (item_ff.operation == OP_TICK);
   assign more_slots = (slot_ff != SLOT_W'(TASK_SLOTS - 1));
   assign idx_ok   = (int'(item_ff.task_index) < TASK_SLOTS);
   assign cmd_slot = SLOT_W'(item_ff.task_index);
   assign cnt_now  = countdown_ff[slot_ff];
   assign live     = present_ff[slot_ff] && resumed_ff[slot_ff];
   assign due      = live && (cnt_now == 16'd0);

   ptts_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .is_tick    (is_tick),
      .more_slots (more_slots),
      .uword      (uword)
   );

   always_comb begin
      slot_in      = slot_ff;
      present_in   = present_ff;
      resumed_in   = resumed_ff;
      pend_in      = pend_ff;
      pend_slot_in = pend_slot_ff;
      strobe_in    = 1'b0;
      rsp_in       = rsp_ff;
      case (uword.action)
         ACT_DISPATCH: begin
            slot_in = '0;
            pend_in = 1'b0;
         end
         ACT_APPLY: begin
            if (idx_ok) begin
               case (item_ff.operation)
                  OP_CREATE: begin
                     present_in[cmd_slot] = 1'b1;
                     resumed_in[cmd_slot] = 1'b1;
                  end
                  OP_DELETE:  present_in[cmd_slot] = 1'b0;
                  OP_SUSPEND: resumed_in[cmd_slot] = 1'b0;
                  OP_RESUME:  resumed_in[cmd_slot] = 1'b1;
                  default:    ;
               endcase
            end
         end
         ACT_SCAN: begin
            slot_in = slot_ff + 1'b1;
            if (due) begin
               // release the held event: another follows, so it is not last
               strobe_in    = pend_ff;
               rsp_in       = '{3'(pend_slot_ff), 1'b0};
               pend_in      = 1'b1;
               pend_slot_in = slot_ff;
            end
         end
         ACT_FLUSH: begin
            strobe_in = pend_ff;
            rsp_in    = '{3'(pend_slot_ff), 1'b1};
            pend_in   = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         resumed_ff <= '0;
         pend_ff    <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         present_ff <= present_in;
         resumed_ff <= resumed_in;
         pend_ff    <= pend_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      slot_ff      <= slot_in;
      pend_slot_ff <= pend_slot_in;
      rsp_ff       <= rsp_in;
   end

   // Slot table: one write per cycle, either from a create or from the scan.
   always_ff @(posedge clock) begin
      if (uword.action == ACT_APPLY && idx_ok && item_ff.operation == OP_CREATE) begin
         period_ff[cmd_slot]    <= item_ff.period;
         countdown_ff[cmd_slot] <= item_ff.first_delay;
      end else if (uword.action == ACT_SCAN && live) begin
         countdown_ff[slot_ff] <= due ? period_ff[slot_ff] : cnt_now - 16'd1;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
